FILE: src/frac_pkg.sv
`default_nettype none

package frac_pkg;

  localparam int DATA_WIDTH = 16;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] numerator_in;
    logic signed [DATA_WIDTH-1:0] denominator_in;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] numerator_out;
    logic signed [DATA_WIDTH-1:0] denominator_out;
    logic                         bad_denominator;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_EUCLID   = 6'b000010,
    ST_MOD_WAIT = 6'b000100,
    ST_QN_WAIT  = 6'b001000,
    ST_QD_WAIT  = 6'b010000,
    ST_DONE     = 6'b100000
  } state_t;

endpackage

`default_nettype wire

FILE: src/frac_div.sv
`default_nettype none

module frac_div #(
  parameter int Width = frac_pkg::DATA_WIDTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [Width-1:0]   dividend,
  input  wire logic [Width-1:0]   divisor,
  output logic [Width-1:0]        quotient,
  output logic [Width-1:0]        remainder,
  output frac_pkg::div_status_t   status
);
  import frac_pkg::*;

  localparam int CntW = $clog2(Width + 1);

  logic [Width-1:0] quo;
  logic [Width-1:0] rem;
  logic [Width-1:0] dvs;
  logic [CntW-1:0]  cnt;
  logic             busy;
  logic             done;
  logic [Width:0]   trial;
  logic             fits;

  assign trial = {rem, quo[Width-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(Width);
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        if (fits) begin
          rem <= Width'(trial - {1'b0, dvs});
        end else begin
          rem <= trial[Width-1:0];
        end
        quo <= {quo[Width-2:0], fits};
        cnt <= cnt - CntW'(1);
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient    = quo;
  assign remainder   = rem;
  assign status.busy = busy;
  assign status.done = done;

  a_nonzero_divisor: assert property (@(posedge clk) disable iff (rst)
    start |-> divisor != '0)
    else $error("divide started with zero divisor");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> rem < dvs)
    else $error("remainder not below divisor");

endmodule

`default_nettype wire

FILE: src/fraction_reducer.sv
// Reduces a signed fraction to lowest terms: both parts are divided by the greatest common
// divisor of |numerator| and the denominator, found by Euclid's remainder method on one
// shared restoring divider that retires one quotient bit per cycle. An item needs E remainder
// steps (E is at most about 1.45 * DATA_WIDTH, and small for most inputs), then two final
// divisions. A zero or negative denominator sets bad_denominator and returns the inputs
// unchanged, with no division. A zero numerator gives 0/1. One item is in work at a time;
// the next is taken while a finished result still waits in the output register.
`default_nettype none

module fraction_reducer (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire frac_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output frac_pkg::out_item_t      out_data
);
  import frac_pkg::*;

  localparam int W = DATA_WIDTH;

  state_t        state;
  logic [W-1:0]  a;
  logic [W-1:0]  b;
  logic [W-1:0]  mag;
  logic [W-1:0]  den;
  logic          neg;
  out_item_t     res;

  logic          div_start;
  logic [W-1:0]  div_dividend;
  logic [W-1:0]  div_divisor;
  logic [W-1:0]  div_quo;
  logic [W-1:0]  div_rem;
  div_status_t   div_stat;

  logic          in_fire;
  logic          den_bad;
  logic          out_free;

  assign in_ready = state == ST_IDLE;
  assign in_fire  = in_valid && in_ready;
  assign den_bad  = in_data.denominator_in[W-1] || in_data.denominator_in == '0;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = a;
    div_divisor  = b;
    unique case (state)
      ST_EUCLID: begin
        div_start = 1'b1;
        if (b == '0) begin
          div_dividend = mag;
          div_divisor  = a;
        end
      end
      ST_QN_WAIT: begin
        div_start    = div_stat.done;
        div_dividend = den;
        div_divisor  = a;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  frac_div #(
    .Width(W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .remainder(div_rem),
    .status   (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (den_bad) begin
              res.numerator_out   <= in_data.numerator_in;
              res.denominator_out <= in_data.denominator_in;
              res.bad_denominator <= 1'b1;
              state               <= ST_DONE;
            end else begin
              neg   <= in_data.numerator_in[W-1];
              mag   <= in_data.numerator_in[W-1] ? W'(-in_data.numerator_in)
                                                 : W'(in_data.numerator_in);
              a     <= in_data.numerator_in[W-1] ? W'(-in_data.numerator_in)
                                                 : W'(in_data.numerator_in);
              b     <= W'(in_data.denominator_in);
              den   <= W'(in_data.denominator_in);
              state <= ST_EUCLID;
            end
          end
        end
        ST_EUCLID: begin
          state <= (b == '0) ? ST_QN_WAIT : ST_MOD_WAIT;
        end
        ST_MOD_WAIT: begin
          if (div_stat.done) begin
            a     <= b;
            b     <= div_rem;
            state <= ST_EUCLID;
          end
        end
        ST_QN_WAIT: begin
          if (div_stat.done) begin
            res.numerator_out <= neg ? -$signed(div_quo) : $signed(div_quo);
            state             <= ST_QD_WAIT;
          end
        end
        ST_QD_WAIT: begin
          if (div_stat.done) begin
            res.denominator_out <= $signed(div_quo);
            res.bad_denominator <= 1'b0;
            state               <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_busy_only_waiting: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (state == ST_MOD_WAIT || state == ST_QN_WAIT || state == ST_QD_WAIT))
    else $error("divider busy outside a wait state");

  a_good_den_positive: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.bad_denominator |-> !out_data.denominator_out[W-1]
      && out_data.denominator_out != '0)
    else $error("reduced denominator not positive");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("input taken again right after an item");

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_EUCLID && b == '0 |-> a != '0)
    else $error("common divisor is zero");

endmodule

`default_nettype wire

FILE: test/fraction_reducer_check.sv
`timescale 1ns / 1ps

module fraction_reducer_check (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire frac_pkg::in_item_t  in_data,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire frac_pkg::out_item_t out_data,
  output int                       fails,
  output int                       outstanding,
  output int                       reduced_seen,
  output int                       flagged_seen
);
  import frac_pkg::*;

  out_item_t expected_reduced[$];

  function automatic out_item_t reduce_fraction(in_item_t item);
    out_item_t r;
    longint num;
    longint den;
    longint mag;
    longint a;
    longint b;
    longint t;
    num = longint'($signed(item.numerator_in));
    den = longint'($signed(item.denominator_in));
    if (den <= 0) begin
      r.numerator_out = item.numerator_in;
      r.denominator_out = item.denominator_in;
      r.bad_denominator = 1'b1;
      return r;
    end
    mag = (num < 0) ? -num : num;
    a = mag;
    b = den;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    r.numerator_out = DATA_WIDTH'((num < 0) ? -(mag / a) : (mag / a));
    r.denominator_out = DATA_WIDTH'(den / a);
    r.bad_denominator = 1'b0;
    return r;
  endfunction

  initial begin
    fails = 0;
    outstanding = 0;
    reduced_seen = 0;
    flagged_seen = 0;
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        reduced_seen = reduced_seen + 1;
        if (out_data.bad_denominator) flagged_seen = flagged_seen + 1;
        if (expected_reduced.size() == 0) begin
          $error("unexpected result item %0d/%0d", out_data.numerator_out,
                 out_data.denominator_out);
          fails = fails + 1;
        end else begin
          want = expected_reduced.pop_front();
          if (out_data.numerator_out !== want.numerator_out) begin
            $error("numerator_out: expected %0d, got %0d", want.numerator_out,
                   out_data.numerator_out);
            fails = fails + 1;
          end
          if (out_data.denominator_out !== want.denominator_out) begin
            $error("denominator_out: expected %0d, got %0d", want.denominator_out,
                   out_data.denominator_out);
            fails = fails + 1;
          end
          if (out_data.bad_denominator !== want.bad_denominator) begin
            $error("bad_denominator: expected %0b, got %0b", want.bad_denominator,
                   out_data.bad_denominator);
            fails = fails + 1;
          end
        end
      end
      if (in_valid && in_ready) expected_reduced.push_back(reduce_fraction(in_data));
      outstanding = expected_reduced.size();
    end
  end

endmodule

FILE: test/fraction_reducer_test.sv
`timescale 1ns / 1ps

module fraction_reducer_test;
  import frac_pkg::*;

  localparam int RANDOM_PER_PHASE = 140;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int DRAIN_CYCLES = 500;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int fails;
  int outstanding;
  int reduced_seen;
  int flagged_seen;
  int idle_pct;
  int stall_pct;
  int cycles;
  int sent;

  int idle_by_phase[4] = '{0, 55, 0, 32};
  int stall_by_phase[4] = '{0, 0, 55, 32};

  int dir_num[20] = '{0, 0, 0, -32768, -32768, -32768, 32767, 32767, 1, -1,
                      12, 5, -32768, 28657, -17711, 30030, -4096, 25, 7, -21};
  int dir_den[20] = '{5, 0, -7, 32767, 16384, 1, 32767, 1, 32767, 1,
                      -8, -32768, -32768, 17711, 28657, 2310, 24576, 25, 3, 6};

  fraction_reducer DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  fraction_reducer_check checker_inst (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .fails        (fails),
    .outstanding  (outstanding),
    .reduced_seen (reduced_seen),
    .flagged_seen (flagged_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items still expected", cycles, outstanding);
      $display("fraction_reducer: mismatch");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic in_item_t make_fraction(int num, int den);
    in_item_t item;
    item.numerator_in = DATA_WIDTH'(num);
    item.denominator_in = DATA_WIDTH'(den);
    return item;
  endfunction

  function automatic in_item_t random_fraction();
    int kind;
    int factor;
    int num;
    int den;
    kind = $urandom_range(0, 9);
    num = 0;
    den = 1;
    if (kind <= 2) begin
      num = $urandom();
      den = $urandom();
    end else if (kind <= 6) begin
      // shared factor so the search has real work to do
      factor = ($urandom_range(0, 3) == 0) ? (1 << $urandom_range(0, 10))
                                           : $urandom_range(1, 300);
      num = $urandom_range(0, 32767 / factor) * factor;
      den = $urandom_range(1, 32767 / factor) * factor;
      if ($urandom_range(0, 1) == 1) num = -num;
    end else if (kind == 7) begin
      num = ($urandom_range(0, 2) == 0) ? -32768 : (int'($urandom_range(1, 255)) << 7);
      den = (1 << $urandom_range(0, 14)) * (2 * $urandom_range(0, 1) + 1);
      if ($urandom_range(0, 1) == 1) num = -num;
    end else if (kind == 8) begin
      num = $urandom();
      den = ($urandom_range(0, 3) == 0) ? 0 : -int'($urandom_range(1, 32768));
    end else begin
      num = int'($urandom_range(0, 100)) - 50;
      den = $urandom_range(1, 50);
    end
    return make_fraction(num, den);
  endfunction

  task automatic send_fraction(in_item_t item);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    sent = sent + 1;
    @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    cycles = 0;
    sent = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = idle_by_phase[phase];
      stall_pct = stall_by_phase[phase];
      if (phase == 0) begin
        for (int i = 0; i < 20; i++) send_fraction(make_fraction(dir_num[i], dir_den[i]));
      end
      for (int i = 0; i < RANDOM_PER_PHASE; i++) send_fraction(random_fraction());
    end
    in_valid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d fractions through four idle/stall phases in %0d cycles", sent, cycles);
    $display("checked %0d results, %0d with a bad denominator", reduced_seen, flagged_seen);
    if (fails == 0) begin
      $display("fraction_reducer: match");
    end else begin
      $display("fraction_reducer: mismatch");
    end
    $finish;
  end

endmodule
